// ----- rtl/core/cbc_pkg.sv -----
// shared types and constants for the cartridge bank controller
package cbc_pkg;

  // internal ram store
  localparam int RAM_DEPTH = 32768;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // rom address space
  localparam int ROM_ADDR_WIDTH = 21;
  localparam logic [4:0]  ROM_LG_MIN = 5'd15;
  localparam logic [4:0]  ROM_LG_MAX = 5'(ROM_ADDR_WIDTH);
  localparam logic [20:0] ROM_WIDTH_MASK = 21'((22'(1) << ROM_ADDR_WIDTH) - 22'd1);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // values written to the mbc registers
  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [4:0] ROM_BANK_ZERO = 5'd0;
  localparam logic [4:0] ROM_BANK_ONE  = 5'd1;
  localparam logic [7:0] MODE_VAL_0 = 8'd0;
  localparam logic [7:0] MODE_VAL_1 = 8'd1;

  // address windows, decoded on address[15:13]
  localparam logic [2:0] WIN_RAM_EN   = 3'b000;
  localparam logic [2:0] WIN_ROM_BANK = 3'b001;
  localparam logic [2:0] WIN_UPPER    = 3'b010;
  localparam logic [2:0] WIN_MODE     = 3'b011;
  localparam logic [2:0] WIN_RAM      = 3'b101;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_SIZE_LOG2   = 2'd0;
  localparam logic [1:0] CFG_RAM_ADDR_BITS   = 2'd1;
  localparam logic [1:0] CFG_BATTERY_PRESENT = 2'd2;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_RAM_EN_WR,
    CMD_ROM_BANK_WR,
    CMD_UPPER_WR,
    CMD_MODE_WR,
    CMD_RAM_WR,
    CMD_ROM_LO_RD,
    CMD_ROM_HI_RD,
    CMD_RAM_RD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [13:0] offset;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [4:0] rom_size_log2;
    logic [3:0] ram_addr_bits;
    logic       battery_present;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_access;
    logic [20:0] rom_address;
    logic        save_request;
  } out_t;

endpackage

// ----- rtl/core/cbc_ram.sv -----
// generic single write port ram with registered read
module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/cbc_front.sv -----
// front end: accepts bus accesses and classifies them into commands
module cbc_front (
  input  cbc_pkg::in_t  in_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          q_full,
  output logic          push,
  output cbc_pkg::cmd_t cmd
);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.offset = in_data.address[13:0];
    cmd.data   = in_data.write_data;
    cmd.kind   = cbc_pkg::CMD_NOP;
    if (in_data.mode) begin
      unique case (in_data.address[15:13])
        cbc_pkg::WIN_RAM_EN:   cmd.kind = cbc_pkg::CMD_RAM_EN_WR;
        cbc_pkg::WIN_ROM_BANK: cmd.kind = cbc_pkg::CMD_ROM_BANK_WR;
        cbc_pkg::WIN_UPPER:    cmd.kind = cbc_pkg::CMD_UPPER_WR;
        cbc_pkg::WIN_MODE:     cmd.kind = cbc_pkg::CMD_MODE_WR;
        cbc_pkg::WIN_RAM:      cmd.kind = cbc_pkg::CMD_RAM_WR;
        default:               cmd.kind = cbc_pkg::CMD_NOP;
      endcase
    end else if (!in_data.address[15]) begin
      cmd.kind = in_data.address[14] ? cbc_pkg::CMD_ROM_HI_RD : cbc_pkg::CMD_ROM_LO_RD;
    end else if (in_data.address[15:13] == cbc_pkg::WIN_RAM) begin
      cmd.kind = cbc_pkg::CMD_RAM_RD;
    end
  end

endmodule

// ----- rtl/core/cbc_queue.sv -----
// short command queue between front and back
module cbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cbc_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output cbc_pkg::cmd_t pop_data,
  output logic          not_empty
);

  cbc_pkg::cmd_t            entries [cbc_pkg::QDEPTH];
  logic [cbc_pkg::QAW-1:0]  wr_ptr;
  logic [cbc_pkg::QAW-1:0]  rd_ptr;
  logic [cbc_pkg::QAW:0]    count;

  assign full      = (count == (cbc_pkg::QAW+1)'(cbc_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/cbc_back.sv -----
// back end: bank registers, rom translation, ram access and result register
module cbc_back (
  input  logic          clk,
  input  logic          rst,
  input  cbc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  cbc_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output cbc_pkg::out_t out_data
);

  logic [4:0] rom_bank;
  logic [1:0] upper_bank;
  logic       bank_mode;
  logic       ram_enabled;
  logic       ram_dirty;

  logic        r_valid;
  logic        r_ram_rd;
  logic        r_rom_access;
  logic [20:0] r_rom_address;
  logic        r_save;

  logic                      ram_usable;
  logic [14:0]               ram_off;
  logic [15:0]               ram_mask;
  logic [14:0]               ram_idx;
  logic [cbc_pkg::RAM_AW-1:0] ram_addr;
  logic                      ram_we;
  logic                      ram_re;
  logic [7:0]                ram_rdata;

  logic [4:0]  rom_lg;
  logic [6:0]  rom_bank_full;
  logic [21:0] rom_mask_w;
  logic [20:0] rom_addr_calc;

  logic       en_val;
  logic       save_now;
  logic [4:0] bank_wr;

  assign pop = q_valid && (!r_valid || out_ready);

  // ram index: window offset, upper bank in mode 1, masked to fitted size
  assign ram_usable = ram_enabled && (cfg.ram_addr_bits != 4'd0);
  assign ram_off    = {bank_mode ? upper_bank : 2'b00, cmd.offset[12:0]};
  assign ram_mask   = (16'(1) << cfg.ram_addr_bits) - 16'd1;
  assign ram_idx    = ram_off & ram_mask[14:0];
  assign ram_addr   = ram_idx[cbc_pkg::RAM_AW-1:0];
  assign ram_we     = pop && (cmd.kind == cbc_pkg::CMD_RAM_WR) && ram_usable;
  assign ram_re     = pop && (cmd.kind == cbc_pkg::CMD_RAM_RD) && ram_usable;

  // rom translation, upper half banked and masked to the rom size
  always_comb begin
    rom_lg = cfg.rom_size_log2;
    if (rom_lg < cbc_pkg::ROM_LG_MIN) begin
      rom_lg = cbc_pkg::ROM_LG_MIN;
    end else if (rom_lg > cbc_pkg::ROM_LG_MAX) begin
      rom_lg = cbc_pkg::ROM_LG_MAX;
    end
  end

  assign rom_bank_full = bank_mode ? {2'b00, rom_bank} : {upper_bank, rom_bank};
  assign rom_mask_w    = (22'(1) << rom_lg) - 22'd1;

  always_comb begin
    if (cmd.kind == cbc_pkg::CMD_ROM_HI_RD) begin
      rom_addr_calc = {rom_bank_full, cmd.offset} & rom_mask_w[20:0];
    end else begin
      rom_addr_calc = {7'd0, cmd.offset};
    end
    rom_addr_calc = rom_addr_calc & cbc_pkg::ROM_WIDTH_MASK;
  end

  assign en_val   = (cmd.data[3:0] == cbc_pkg::RAM_EN_KEY);
  assign save_now = (cmd.kind == cbc_pkg::CMD_RAM_EN_WR) && cfg.battery_present &&
                    ram_enabled && !en_val && ram_dirty;
  assign bank_wr  = (cmd.data[4:0] == cbc_pkg::ROM_BANK_ZERO) ? cbc_pkg::ROM_BANK_ONE
                                                               : cmd.data[4:0];

  // bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= cbc_pkg::ROM_BANK_ONE;
      upper_bank  <= 2'd0;
      bank_mode   <= 1'b0;
      ram_enabled <= 1'b0;
      ram_dirty   <= 1'b0;
    end else if (pop) begin
      unique case (cmd.kind)
        cbc_pkg::CMD_RAM_EN_WR: begin
          ram_enabled <= en_val;
          if (save_now) begin
            ram_dirty <= 1'b0;
          end
        end
        cbc_pkg::CMD_ROM_BANK_WR: rom_bank <= bank_wr;
        cbc_pkg::CMD_UPPER_WR:    upper_bank <= cmd.data[1:0];
        cbc_pkg::CMD_MODE_WR: begin
          if (cmd.data == cbc_pkg::MODE_VAL_0) begin
            bank_mode <= 1'b0;
          end else if (cmd.data == cbc_pkg::MODE_VAL_1) begin
            bank_mode <= 1'b1;
          end
        end
        cbc_pkg::CMD_RAM_WR: begin
          if (ram_usable) begin
            ram_dirty <= 1'b1;
          end
        end
        cbc_pkg::CMD_NOP, cbc_pkg::CMD_ROM_LO_RD, cbc_pkg::CMD_ROM_HI_RD,
        cbc_pkg::CMD_RAM_RD: ;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid <= 1'b1;
    end else if (out_ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_ram_rd      <= ram_re;
      r_rom_access  <= (cmd.kind == cbc_pkg::CMD_ROM_LO_RD) ||
                       (cmd.kind == cbc_pkg::CMD_ROM_HI_RD);
      r_rom_address <= ((cmd.kind == cbc_pkg::CMD_ROM_LO_RD) ||
                        (cmd.kind == cbc_pkg::CMD_ROM_HI_RD)) ? rom_addr_calc : 21'd0;
      r_save        <= save_now;
    end
  end

  cbc_ram #(
    .WIDTH(8),
    .DEPTH(cbc_pkg::RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(cmd.data),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  assign out_valid             = r_valid;
  assign out_data.read_data    = r_ram_rd ? ram_rdata : 8'd0;
  assign out_data.rom_access   = r_rom_access;
  assign out_data.rom_address  = r_rom_address;
  assign out_data.save_request = r_save;

  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    rom_bank != cbc_pkg::ROM_BANK_ZERO)
    else $error("rom bank register holds zero");

  a_ram_write_dirty: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> ram_dirty)
    else $error("ram write did not mark ram dirty");

  a_read_reaches_result: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (r_valid && r_ram_rd && !r_rom_access))
    else $error("ram read not tracked in result register");

  a_save_exclusive: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_save) |-> (!r_rom_access && !r_ram_rd))
    else $error("save request on a read beat");

endmodule

// ----- rtl/core/cartridge_bank_controller.sv -----
// top level of the cartridge bank controller
// One bus access per in beat, one result per out beat, in order. The block
// sustains one beat per clock while out_ready is held high: the front decodes
// each access into a command and pushes it into a two-entry queue, and the
// back pops one command per cycle, updates the bank registers, drives the
// internal ram and loads the result register. An accepted in beat passes
// through a queue entry, then the result register, before it shows as a valid
// out beat. The back stalls only while a result waits on out_ready; the
// front keeps taking beats until the queue is full. Reads of 0000-7fff return
// a translated rom byte address with rom_access set; the rom itself lives
// outside. Reads of a000-bfff return the ram byte when ram is enabled and
// fitted, otherwise 0. Ram contents are not cleared at reset; reading a byte
// never written returns an undefined value. Configuration writes are taken
// every cycle (cfg_ready is always high) and must be issued while idle.
module cartridge_bank_controller (
  input  logic          clk,
  input  logic          rst,
  // access channel
  input  logic          in_valid,
  output logic          in_ready,
  input  cbc_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output cbc_pkg::out_t out_data,
  // configuration write channel
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data
);

  cbc_pkg::cfg_t cfg;
  cbc_pkg::cmd_t front_cmd;
  cbc_pkg::cmd_t q_cmd;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_valid;

  // configuration registers, index beyond the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_size_log2   <= cbc_pkg::ROM_LG_MIN;
      cfg.ram_addr_bits   <= 4'd0;
      cfg.battery_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cbc_pkg::CFG_ROM_SIZE_LOG2:   cfg.rom_size_log2   <= cfg_data;
        cbc_pkg::CFG_RAM_ADDR_BITS:   cfg.ram_addr_bits   <= cfg_data[3:0];
        cbc_pkg::CFG_BATTERY_PRESENT: cfg.battery_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  cbc_front u_front (
    .in_data (in_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .q_full  (q_full),
    .push    (push),
    .cmd     (front_cmd)
  );

  // queue decouples acceptance from execution
  cbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_data (q_cmd),
    .not_empty(q_valid)
  );

  // back: execute and hold the result beat
  cbc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .cmd      (q_cmd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- test/tb_cartridge_bank_controller.sv -----
// testbench for the cartridge bank controller: directed bus accesses, then random traffic
module tb_cartridge_bank_controller;
  import cbc_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RAND_PER_SETTING = 100;
  localparam int SHOWN_FAULTS = 10;

  // access kinds carried in in_t.mode
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;
  // register index that the block does not decode
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam out_t ZERO_RESULT = '0;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] cfg_idx;
    logic [4:0] cfg_val;
    in_t        acc;
    logic       typed;
    out_t       want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  cartridge_bank_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of the controller: configuration, bank registers, ram image
  logic [4:0]  mdl_rom_lg = 5'd15;
  logic [3:0]  mdl_ram_bits = 4'd0;
  logic        mdl_battery = 1'b0;
  logic [4:0]  mdl_rom_bank = 5'd1;
  logic [1:0]  mdl_upper = 2'd0;
  logic        mdl_mode = 1'b0;
  logic        mdl_ram_on = 1'b0;
  logic        mdl_dirty = 1'b0;
  logic [7:0]  ram_image [RAM_DEPTH];
  bit          ram_written [RAM_DEPTH];

  out_t        pending_results [$];
  logic [15:0] recent_ram_addr [$];
  step_row_t   script [$];

  int send_idle = 0;
  int recv_idle = 0;
  int fault_count = 0;
  int accesses_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int saves_seen = 0;

  // ram slot of a bus address: window offset, upper bank in mode 1, masked to ram size
  function automatic logic [14:0] ram_slot(input logic [15:0] a);
    logic [14:0] off;
    logic [15:0] span;
    off = {2'b00, a[12:0]};
    if (mdl_mode)
      off[14:13] = mdl_upper;
    span = (16'd1 << mdl_ram_bits) - 16'd1;
    return off & span[14:0];
  endfunction

  // physical rom byte address; only the upper 16 KB is banked and masked
  function automatic logic [20:0] rom_phys(input logic [15:0] a);
    logic [4:0]  lg;
    logic [6:0]  bank;
    logic [21:0] span;
    logic [20:0] pa;
    pa = {7'd0, a[13:0]};
    if (a[14]) begin
      lg = mdl_rom_lg;
      if (lg < ROM_LG_MIN)
        lg = ROM_LG_MIN;
      if (lg > ROM_LG_MAX)
        lg = ROM_LG_MAX;
      // mode polarity kept as the design has it: mode 1 drops the upper bank
      bank = mdl_mode ? {2'b00, mdl_rom_bank} : {mdl_upper, mdl_rom_bank};
      pa = {bank, a[13:0]};
      span = (22'd1 << lg) - 22'd1;
      pa = pa & span[20:0];
    end
    return pa;
  endfunction

  // one bus access: update the shadow state and return the result it gives
  function automatic out_t predict_access(input in_t acc);
    out_t        r;
    logic        ram_ok;
    logic        en;
    logic [14:0] slot;
    r = '0;
    ram_ok = mdl_ram_on && (mdl_ram_bits != 4'd0);
    if (acc.mode == ACC_WRITE) begin
      case (acc.address[15:13])
        WIN_RAM_EN: begin
          en = (acc.write_data[3:0] == RAM_EN_KEY);
          if (mdl_battery && mdl_ram_on && !en && mdl_dirty) begin
            r.save_request = 1'b1;
            mdl_dirty = 1'b0;
          end
          mdl_ram_on = en;
        end
        WIN_ROM_BANK: begin
          mdl_rom_bank = (acc.write_data[4:0] == ROM_BANK_ZERO) ? ROM_BANK_ONE
                                                               : acc.write_data[4:0];
        end
        WIN_UPPER: mdl_upper = acc.write_data[1:0];
        WIN_MODE: begin
          if (acc.write_data == MODE_VAL_0)
            mdl_mode = 1'b0;
          else if (acc.write_data == MODE_VAL_1)
            mdl_mode = 1'b1;
        end
        WIN_RAM: begin
          if (ram_ok) begin
            slot = ram_slot(acc.address);
            ram_image[slot] = acc.write_data;
            ram_written[slot] = 1'b1;
            mdl_dirty = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (!acc.address[15]) begin
      r.rom_access = 1'b1;
      r.rom_address = rom_phys(acc.address);
    end else if (acc.address[15:13] == WIN_RAM && ram_ok) begin
      r.read_data = ram_image[ram_slot(acc.address)];
    end
    return r;
  endfunction

  // a read of a ram byte that was never written has no defined answer
  function automatic bit hits_blank_ram(input in_t acc);
    return acc.mode == ACC_READ && acc.address[15:13] == WIN_RAM && mdl_ram_on &&
           mdl_ram_bits != 4'd0 && !ram_written[ram_slot(acc.address)];
  endfunction

  function automatic step_row_t acc_row(input logic md, input logic [15:0] a,
                                        input logic [7:0] d, input int typed,
                                        input out_t want);
    step_row_t s;
    s = '0;
    s.acc.mode = md;
    s.acc.address = a;
    s.acc.write_data = d;
    s.typed = 1'(typed);
    s.want = want;
    return s;
  endfunction

  function automatic step_row_t cfg_row(input logic [1:0] idx, input logic [4:0] v);
    step_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic out_t bus_result(input logic [7:0] rd, input int ra,
                                      input logic [20:0] pa, input int sv);
    out_t r;
    r.read_data = rd;
    r.rom_access = 1'(ra);
    r.rom_address = pa;
    r.save_request = 1'(sv);
    return r;
  endfunction

  // random access with a bias toward register writes and ram traffic
  function automatic in_t random_access();
    in_t acc;
    int  p;
    int  sub;
    acc.mode = 1'($urandom_range(1));
    acc.address = 16'($urandom);
    acc.write_data = 8'($urandom);
    p = $urandom_range(99);
    if (p < 30) begin
      acc.address = {WIN_RAM, 13'($urandom)};
      if (recent_ram_addr.size() != 0 && $urandom_range(1) == 1)
        acc.address = recent_ram_addr[$urandom_range(recent_ram_addr.size() - 1)];
    end else if (p < 45) begin
      acc.mode = ACC_READ;
      acc.address[15] = 1'b0;
    end else if (p < 70) begin
      sub = $urandom_range(3);
      acc.mode = ACC_WRITE;
      acc.address[15:13] = {1'b0, 2'(sub)};
      if (sub == 0 && $urandom_range(99) < 70)
        acc.write_data[3:0] = RAM_EN_KEY;
      else if (sub == 3 && $urandom_range(99) < 80)
        acc.write_data = 8'($urandom_range(1));
    end else if (p < 80) begin
      // unmapped windows 8000-9fff and c000-ffff
      if ($urandom_range(1) == 1)
        acc.address[15:13] = 3'b100;
      else
        acc.address[15:14] = 2'b11;
    end
    if (hits_blank_ram(acc))
      acc.mode = ACC_WRITE;
    if (acc.mode == ACC_WRITE && acc.address[15:13] == WIN_RAM) begin
      recent_ram_addr.push_back(acc.address);
      if (recent_ram_addr.size() > 16)
        void'(recent_ram_addr.pop_front());
    end
    return acc;
  endfunction

  // drive one access beat and record what it should return once accepted
  task automatic send_access(input in_t acc, input logic typed, input out_t want);
    out_t r;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    r = predict_access(acc);
    pending_results.push_back(typed ? want : r);
    accesses_sent++;
  endtask

  // registers are only written with no access in flight
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      CFG_ROM_SIZE_LOG2: mdl_rom_lg = v;
      CFG_RAM_ADDR_BITS: mdl_ram_bits = v[3:0];
      CFG_BATTERY_PRESENT: mdl_battery = v[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // result side: random back-pressure, compare each beat with the oldest expectation
  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (out_data.save_request)
        saves_seen++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
          $display("unexpected result beat: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data ||
            out_data.rom_access !== want.rom_access ||
            out_data.rom_address !== want.rom_address ||
            out_data.save_request !== want.save_request) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS)
            $display({"mismatch on result %0d: expected rd=%h rom=%b addr=%h save=%b,",
                      " got rd=%h rom=%b addr=%h save=%b"},
                     results_checked, want.read_data, want.rom_access, want.rom_address,
                     want.save_request, out_data.read_data, out_data.rom_access,
                     out_data.rom_address, out_data.save_request);
        end
      end
    end
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin : watchdog
    #(CLK_PERIOD * 200000);
    $display("timeout: controller stopped making progress");
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    step_row_t s;
    int        drain;
    int        k;

    // directed part, reset state first
    script.push_back(acc_row(ACC_READ,  16'h0000, 8'h00, 1, bus_result(8'h00, 1, 21'h0000, 0)));
    script.push_back(acc_row(ACC_READ,  16'h3FFF, 8'hFF, 1, bus_result(8'h00, 1, 21'h3FFF, 0)));
    script.push_back(acc_row(ACC_READ,  16'h4000, 8'h00, 1, bus_result(8'h00, 1, 21'h4000, 0)));
    script.push_back(acc_row(ACC_READ,  16'h7FFF, 8'h00, 1, bus_result(8'h00, 1, 21'h7FFF, 0)));
    // rom bank zero turns into one, then the widest bank value
    script.push_back(acc_row(ACC_WRITE, 16'h2000, 8'h00, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h3FFF, 8'hFF, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_READ,  16'h4000, 8'h00, 0, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h4000, 8'hFF, 1, ZERO_RESULT));
    // mode register ignores anything but 0 and 1
    script.push_back(acc_row(ACC_WRITE, 16'h6000, 8'h02, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h7FFF, 8'h01, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_READ,  16'h4000, 8'h00, 0, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h6000, 8'h00, 1, ZERO_RESULT));
    // unmapped windows and the ram window with ram off or not fitted
    script.push_back(acc_row(ACC_READ,  16'hFFFF, 8'h00, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'hC000, 8'hAA, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_READ,  16'hA000, 8'h00, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h0000, 8'h0A, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'hBFFF, 8'h55, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_READ,  16'hBFFF, 8'h00, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'h1FFF, 8'hF0, 1, ZERO_RESULT));
    // largest rom and ram, battery fitted
    script.push_back(cfg_row(CFG_ROM_SIZE_LOG2, 5'd21));
    script.push_back(cfg_row(CFG_RAM_ADDR_BITS, 5'd15));
    script.push_back(cfg_row(CFG_BATTERY_PRESENT, 5'd1));
    script.push_back(acc_row(ACC_READ,  16'h7FFF, 8'h00, 1, bus_result(8'h00, 1, 21'h1FFFFF, 0)));
    script.push_back(acc_row(ACC_WRITE, 16'h0000, 8'h3A, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_WRITE, 16'hA000, 8'hFF, 1, ZERO_RESULT));
    script.push_back(acc_row(ACC_READ,  16'hA000, 8'h00, 1, bus_result(8'hFF, 0, 21'h0, 0)));
    // disabling dirty battery ram asks for a save, a second disable does not
    script.push_back(acc_row(ACC_WRITE, 16'h1000, 8'h00, 1, bus_result(8'h00, 0, 21'h0, 1)));
    script.push_back(acc_row(ACC_WRITE, 16'h1000, 8'h00, 1, ZERO_RESULT));
    // rom size below and above the legal range saturates; index 3 is dropped
    script.push_back(cfg_row(CFG_ROM_SIZE_LOG2, 5'd0));
    script.push_back(cfg_row(CFG_UNUSED, 5'd31));
    script.push_back(acc_row(ACC_READ,  16'h7FFF, 8'h00, 1, bus_result(8'h00, 1, 21'h7FFF, 0)));
    script.push_back(cfg_row(CFG_ROM_SIZE_LOG2, 5'd31));
    script.push_back(acc_row(ACC_READ,  16'h4000, 8'h00, 0, ZERO_RESULT));

    send_idle = 33;
    recv_idle = 72;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      s = script[i];
      if (s.is_cfg)
        write_reg(s.cfg_idx, s.cfg_val);
      else
        send_access(s.acc, s.typed, s.want);
    end

    // random part: three traffic patterns, four configurations each
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 72;
        recv_idle = 33;
      end else if (ph == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (k = 0; k < 4; k++) begin
        if (k == 0) begin
          write_reg(CFG_ROM_SIZE_LOG2, ROM_LG_MIN);
          write_reg(CFG_RAM_ADDR_BITS, 5'd15);
          write_reg(CFG_BATTERY_PRESENT, 5'd1);
        end else if (k == 1) begin
          write_reg(CFG_ROM_SIZE_LOG2, ROM_LG_MAX);
          write_reg(CFG_RAM_ADDR_BITS, 5'd1);
          write_reg(CFG_BATTERY_PRESENT, 5'd0);
        end else begin
          if ($urandom_range(3) == 0)
            write_reg(CFG_ROM_SIZE_LOG2, 5'($urandom));
          else
            write_reg(CFG_ROM_SIZE_LOG2, 5'($urandom_range(15, 21)));
          write_reg(CFG_RAM_ADDR_BITS, 5'($urandom));
          write_reg(CFG_BATTERY_PRESENT, 5'($urandom));
        end
        for (int n = 0; n < RAND_PER_SETTING; n++)
          send_access(random_access(), 1'b0, ZERO_RESULT);
      end
    end

    // drain, then give a stray extra beat a chance to show up
    in_valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      fault_count += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end

    $display("covered %0d bus accesses and %0d register writes under three handshake patterns",
             accesses_sent, reg_writes);
    $display("checked %0d result beats, %0d of them save requests, %0d faults",
             results_checked, saves_seen, fault_count);
    if (fault_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
